[rtl/core/ithf_pkg.sv]
// ----------------------------------------------------------------------------
// ithf_pkg: shared types and constants for the image trailer hash finder
// Record layout constants, scan phases, status codes and the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

package ithf_pkg;

  localparam int LENGTH_BITS       = 24;
  localparam int POSITION_BITS_DEF = 24;
  localparam int OFFSET_BITS       = 34;

  localparam logic [15:0] HASH_RECORD_TYPE = 16'h0010;
  localparam logic [15:0] HASH_BYTES       = 16'd32;
  localparam int          RECORD_HEAD      = 4;
  localparam int          TRAILER_GAP      = 4;
  localparam int          HEADER_END       = 16;

  // header byte positions
  localparam logic [3:0] POS_HDR_LO  = 4'd8;
  localparam logic [3:0] POS_HDR_HI  = 4'd9;
  localparam logic [3:0] POS_PROT_LO = 4'd10;
  localparam logic [3:0] POS_PROT_HI = 4'd11;
  localparam logic [3:0] POS_BODY_0  = 4'd12;
  localparam logic [3:0] POS_BODY_1  = 4'd13;
  localparam logic [3:0] POS_BODY_2  = 4'd14;
  localparam logic [3:0] POS_BODY_3  = 4'd15;

  // byte of a record head
  localparam logic [1:0] REL_TYPE_LO = 2'd0;
  localparam logic [1:0] REL_TYPE_HI = 2'd1;
  localparam logic [1:0] REL_LEN_LO  = 2'd2;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_RECORD = 4'b0010,
    PH_HASH   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_HEAD_TRUNC  = 3'd1,
    ST_VALUE_TRUNC = 3'd2,
    ST_BAD_LENGTH  = 3'd3,
    ST_OVERLAP     = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] hash_byte;
    logic [4:0] hash_index;
    logic       is_final;
    status_t    status;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/ithf_scan.sv]
// ----------------------------------------------------------------------------
// ithf_scan: byte scanner for the image trailer
// Tracks the byte position, captures the header sizes, walks the trailer
// records and produces at most one result per image byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ithf_scan #(
  parameter int POSITION_BITS = ithf_pkg::POSITION_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               step,
  input  wire logic [7:0]                         image_byte,
  input  wire logic [ithf_pkg::LENGTH_BITS-1:0]   image_length,
  output ithf_pkg::result_t                       res,
  output logic                                    fire
);
  import ithf_pkg::*;

  localparam int LW = ((POSITION_BITS > LENGTH_BITS) ? POSITION_BITS : LENGTH_BITS) + 1;
  localparam int OW = OFFSET_BITS;
  localparam int EW = OFFSET_BITS + 1;

  logic [POSITION_BITS-1:0] pos;
  phase_t                   phase;
  phase_t                   phase_next;
  logic [15:0]              header_len;
  logic [15:0]              prot_size;
  logic [23:0]              body_low;
  logic [17:0]              base_sum;
  logic [OW-1:0]            rec_off;
  logic [OW-1:0]            rec_off_next;
  logic [EW-1:0]            head_end;
  logic [EW-1:0]            head_end_next;
  logic [15:0]              rec_type;
  logic [15:0]              rec_type_next;
  logic [7:0]               len_lo;
  logic [7:0]               len_lo_next;
  logic [4:0]               hash_cnt;
  logic [4:0]               hash_cnt_next;

  logic [LW-1:0] len_ext;
  logic [LW-1:0] limit;
  logic [LW-1:0] eff;
  logic [LW-1:0] eff_m4;
  logic          eff_small;
  logic          last;
  logic          pos_small;
  logic [3:0]    pos_lo;
  logic [OW-1:0] start;
  logic          in_head;
  logic [1:0]    rel;
  logic [15:0]   rec_len;
  logic [EW-1:0] rec_end;
  logic [OW-1:0] rec_end_m;
  logic          fail;
  status_t       fail_code;

  // true when a record head starting at x would run past the image end
  function automatic logic past_limit(input logic [EW-1:0] x, input logic too_short,
                                      input logic [LW-1:0] lim_m4);
    return too_short || (x > EW'(lim_m4));
  endfunction

  assign len_ext   = LW'(image_length);
  assign limit     = LW'(1) << POSITION_BITS;
  assign eff       = (len_ext < limit) ? len_ext : limit;
  assign eff_small = eff < LW'(RECORD_HEAD);
  assign eff_m4    = eff - LW'(RECORD_HEAD);
  assign last      = (LW'(pos) + LW'(1)) >= eff;

  assign pos_small = pos[POSITION_BITS-1:4] == '0;
  assign pos_lo    = pos[3:0];

  // trailer start: precomputed header + protected + gap, plus the body size
  assign start     = OW'({image_byte, body_low}) + OW'(base_sum);

  assign in_head   = (EW'(pos) >= EW'(rec_off)) && (EW'(pos) < head_end);
  assign rel       = pos[1:0] - rec_off[1:0];
  assign rec_len   = {image_byte, len_lo};
  assign rec_end   = head_end + EW'(rec_len);
  assign rec_end_m = rec_end[OW-1:0];

  always_comb begin
    phase_next    = phase;
    rec_off_next  = rec_off;
    head_end_next = head_end;
    rec_type_next = rec_type;
    len_lo_next   = len_lo;
    hash_cnt_next = hash_cnt;
    fail          = 1'b0;
    fail_code     = ST_OK;
    fire          = 1'b0;
    res           = '0;

    case (phase)
      PH_HEADER: begin
        if (pos_small && pos_lo == POS_BODY_3) begin
          rec_off_next  = start;
          head_end_next = EW'(start) + EW'(RECORD_HEAD);
          if (start < OW'(HEADER_END)) begin
            fail      = 1'b1;
            fail_code = ST_OVERLAP;
          end else if (past_limit(EW'(start), eff_small, eff_m4)) begin
            fail      = 1'b1;
            fail_code = ST_HEAD_TRUNC;
          end else begin
            phase_next = PH_RECORD;
          end
        end
      end
      PH_RECORD: begin
        if (in_head) begin
          case (rel)
            REL_TYPE_LO: rec_type_next[7:0]  = image_byte;
            REL_TYPE_HI: rec_type_next[15:8] = image_byte;
            REL_LEN_LO:  len_lo_next         = image_byte;
            default: begin
              if (rec_end > EW'(eff)) begin
                fail      = 1'b1;
                fail_code = ST_VALUE_TRUNC;
              end else if (rec_type == HASH_RECORD_TYPE) begin
                if (rec_len != HASH_BYTES) begin
                  fail      = 1'b1;
                  fail_code = ST_BAD_LENGTH;
                end else begin
                  phase_next    = PH_HASH;
                  hash_cnt_next = '0;
                end
              end else begin
                // skip over this record to the next head
                rec_off_next  = rec_end_m;
                head_end_next = EW'(rec_end_m) + EW'(RECORD_HEAD);
                rec_type_next = '0;
                len_lo_next   = '0;
                if (past_limit(EW'(rec_end_m), eff_small, eff_m4)) begin
                  fail      = 1'b1;
                  fail_code = ST_HEAD_TRUNC;
                end
              end
            end
          endcase
        end
      end
      PH_HASH: begin
        fire           = 1'b1;
        res.hash_byte  = image_byte;
        res.hash_index = hash_cnt;
        res.is_final   = &hash_cnt;
        res.status     = ST_OK;
        hash_cnt_next  = hash_cnt + 5'd1;
        if (&hash_cnt) begin
          phase_next = PH_DONE;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (fail) begin
      fire         = 1'b1;
      res          = '0;
      res.is_final = 1'b1;
      res.status   = fail_code;
      phase_next   = PH_DONE;
    end

    // image ended with no final result yet
    if (last && phase_next != PH_DONE) begin
      fire         = 1'b1;
      res          = '0;
      res.is_final = 1'b1;
      res.status   = (phase_next == PH_HASH) ? ST_VALUE_TRUNC : ST_HEAD_TRUNC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      phase <= PH_HEADER;
    end else if (step) begin
      if (last) begin
        pos   <= '0;
        phase <= PH_HEADER;
      end else begin
        pos   <= pos + POSITION_BITS'(1);
        phase <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rec_off  <= rec_off_next;
      head_end <= head_end_next;
      rec_type <= rec_type_next;
      len_lo   <= len_lo_next;
      hash_cnt <= hash_cnt_next;
      if (phase == PH_HEADER && pos_small) begin
        case (pos_lo)
          POS_HDR_LO:  header_len[7:0]  <= image_byte;
          POS_HDR_HI:  header_len[15:8] <= image_byte;
          POS_PROT_LO: prot_size[7:0]   <= image_byte;
          POS_PROT_HI: prot_size[15:8]  <= image_byte;
          POS_BODY_0: begin
            body_low[7:0] <= image_byte;
            base_sum      <= 18'(header_len) + 18'(prot_size) + 18'(TRAILER_GAP);
          end
          POS_BODY_1:  body_low[15:8]  <= image_byte;
          POS_BODY_2:  body_low[23:16] <= image_byte;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/image_trailer_hash_finder.sv]
// ----------------------------------------------------------------------------
// image_trailer_hash_finder: locates the hash record in a firmware image
// Streams image bytes, walks the trailer records and emits the 32-byte hash
// or one failure result.
// ----------------------------------------------------------------------------
// Usage:
//   Write image_length through cfg_write/cfg_data while the block is idle.
//   Image bytes arrive on in_valid/in_stall/image_byte, one beat per byte in
//   address order; results leave on out_valid/out_stall with hash_byte,
//   hash_index, is_final and status.
//   Throughput is one byte per cycle while the receiver does not stall;
//   a result passes the input register, then scan logic into the result
//   register. Bytes outside the hash record give only failure result beats.
//   The trailer start is one 34-bit add and compare in the scan stage, and
//   each record head is one add and compare on the same path.
//   When the receiver stalls, the result register holds its beat and the
//   input register fills; in_stall rises once both are occupied, so no byte
//   or result is lost.
//   Reset clears the byte position, the scan phase, both valid flags and
//   image_length. After the last byte of an image the scan starts over.
// ----------------------------------------------------------------------------
`default_nettype none

module image_trailer_hash_finder #(
  parameter int POSITION_BITS = ithf_pkg::POSITION_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [ithf_pkg::LENGTH_BITS-1:0] cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       image_byte,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [7:0]                            hash_byte,
  output logic [4:0]                            hash_index,
  output logic                                  is_final,
  output logic [2:0]                            status
);
  import ithf_pkg::*;

  logic [LENGTH_BITS-1:0] image_length;
  logic                   in_full;
  logic [7:0]             in_byte;
  logic                   advance;
  result_t                scan_res;
  logic                   scan_fire;
  result_t                out_res;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_length <= '0;
    end else if (cfg_write) begin
      image_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= image_byte;
    end
  end

  ithf_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .image_byte   (in_byte),
    .image_length (image_length),
    .res          (scan_res),
    .fire         (scan_fire)
  );

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= scan_fire;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && scan_fire) begin
      out_res <= scan_res;
    end
  end

  assign hash_byte  = out_res.hash_byte;
  assign hash_index = out_res.hash_index;
  assign is_final   = out_res.is_final;
  assign status     = out_res.status;

endmodule

`default_nettype wire
